>>> sv/burg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burg_pkg: shared types and helpers
// Word widths, saturation and the divider request bundle.
// ----------------------------------------------------------------------------
package burg_pkg;

  localparam int WORD_W = 32;
  localparam int SUM_W  = 66;

  localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] num;
    logic signed [WORD_W-1:0] den;
  } div_req_t;

  // saturate a wide sum to the signed 32-bit range
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(S32_MAX);
    lo = SUM_W'(S32_MIN);
    if (v > hi) sat32 = S32_MAX;
    else if (v < lo) sat32 = S32_MIN;
    else sat32 = v[WORD_W-1:0];
  endfunction

endpackage

>>> sv/burg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burg_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module burg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 513
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/burg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burg_div: iterative fixed-point divider
// (num << FRAC_BITS) / den, truncated toward zero, saturated; one bit a cycle.
// ----------------------------------------------------------------------------
module burg_div #(
  parameter int FRAC_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  burg_pkg::div_req_t                req,
  output logic                              busy,
  output logic                              done,
  output logic signed [burg_pkg::WORD_W-1:0] quot
);

  localparam int W  = burg_pkg::WORD_W;
  localparam int NB = W + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [NB-1:0] q;
  logic [W-1:0]  dmag;
  logic          neg;

  logic [W-1:0] num_mag;
  logic [W-1:0] den_mag;
  logic [W:0]   trial;
  logic         ge;

  assign num_mag = req.num[W-1] ? W'(-req.num) : W'(req.num);
  assign den_mag = req.den[W-1] ? W'(-req.den) : W'(req.den);
  assign trial   = {rem, q[NB-1]};
  assign ge      = trial >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.den == '0) begin
          // zero pivot: sign of numerator picks the rail, zero numerator gives zero
          if (req.num == '0) quot <= '0;
          else if (!req.num[W-1]) quot <= burg_pkg::S32_MAX;
          else quot <= burg_pkg::S32_MIN;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CW'(NB);
          rem  <= '0;
          q    <= {num_mag, {FRAC_BITS{1'b0}}};
          dmag <= den_mag;
          neg  <= req.num[W-1] ^ req.den[W-1];
        end
      end else if (busy) begin
        if (cnt != '0) begin
          rem <= ge ? W'(trial - {1'b0, dmag}) : trial[W-1:0];
          q   <= {q[NB-2:0], ge};
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (!neg) quot <= (q > NB'(burg_pkg::S32_MAX)) ? burg_pkg::S32_MAX : q[W-1:0];
          else quot <= (q > (NB'(1) << (W - 1))) ? burg_pkg::S32_MIN : W'(-q[W-1:0]);
        end
      end
    end
  end

endmodule

>>> sv/implicit_burgers_grid_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_burgers_grid_step: implicit Burgers' equation grid stepper
// Holds a velocity grid and advances it one implicit step by a tridiagonal solve.
// ----------------------------------------------------------------------------
// A step item (func 0) rebuilds the tridiagonal system from the grid and the new
// left boundary value, solves it with a forward sweep and back substitution and
// writes the solution back; it returns no result. A read item (func 1) returns one
// grid point on point_value with done high for one cycle, the cycle after accept;
// the receiver cannot stall, so sample it when done is high. An item is taken when
// start is high and busy is low. The forward sweep is bound by the one-bit-a-cycle
// divider, used twice per interior row. After reset the grid is set to 1.0 by a
// sweep over every grid point during which busy is high. Write adv_gain (index 0)
// and diff_gain (index 1) only while busy is low.
// ----------------------------------------------------------------------------
module implicit_burgers_grid_step #(
  parameter int GRID_INTERVALS = 512,
  parameter int FRAC_BITS      = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic signed [31:0] boundary_value,
  input  logic [9:0]         read_index,
  output logic               done,
  output logic signed [31:0] point_value,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [30:0]        cfg_data
);

  localparam int W     = burg_pkg::WORD_W;
  localparam int SW    = burg_pkg::SUM_W;
  localparam int NPTS  = GRID_INTERVALS + 1;
  localparam int AW    = $clog2(NPTS);
  localparam int IW    = (AW > 10) ? AW : 10;
  localparam logic [AW-1:0] LAST = AW'(GRID_INTERVALS);
  localparam logic signed [SW-1:0] ONE_Q = SW'(1) <<< FRAC_BITS;

  localparam logic REG_ADV  = 1'b0;
  localparam logic REG_DIFF = 1'b1;

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_FRD   = 15'b000000000000100,  // forward: read grid row
    S_FG    = 15'b000000000001000,  // alpha * u
    S_M1    = 15'b000000000010000,  // lower, diag
    S_M2    = 15'b000000000100000,  // lower * upper_prev
    S_M3    = 15'b000000001000000,  // pivot; lower * rhs_prev
    S_M4    = 15'b000000010000000,  // numerator; start upper divide
    S_DU    = 15'b000000100000000,
    S_DR    = 15'b000001000000000,
    S_B0    = 15'b000010000000000,  // last grid point
    S_BRD   = 15'b000100000000000,  // back: read sweep row
    S_BM    = 15'b001000000000000,
    S_BW    = 15'b010000000000000,
    S_ROUT  = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [30:0] adv_gain;
  logic [30:0] diff_gain;
  logic [AW-1:0] idx;

  logic signed [W-1:0] up_prev, rhs_prev, g, lower, diag, pivot, num, up_cur, g_next, r_b;
  logic signed [64:0]  prod;
  logic signed [64:0]  sh;
  logic signed [32:0]  mul_a;
  logic signed [W-1:0] mul_b;

  logic signed [SW-1:0] au, beta, sh_w;
  logic signed [W-1:0]  upper;
  logic signed [W-1:0]  back_val;

  logic          accept;
  logic [IW-1:0] rd_ext;
  logic [AW-1:0] rd_addr;

  logic          grid_we;
  logic [AW-1:0] grid_waddr, grid_raddr;
  logic [W-1:0]  grid_wdata, grid_rdata;
  logic          sw_we;
  logic [AW-1:0] sw_addr;
  logic [W-1:0]  up_wdata, rhs_wdata, up_rdata, rhs_rdata;

  burg_pkg::div_req_t   div_req;
  logic                 div_busy, div_done;
  logic signed [W-1:0]  div_quot;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign done   = (state == S_ROUT);
  assign point_value = grid_rdata;

  // index clamp: above the last point reads the last point
  assign rd_ext  = IW'(read_index);
  assign rd_addr = (rd_ext > IW'(GRID_INTERVALS)) ? LAST : AW'(rd_ext);

  assign sh    = prod >>> FRAC_BITS;  // floor rounding
  assign sh_w  = SW'(sh);
  assign au    = sh_w;
  assign beta  = SW'($signed({1'b0, diff_gain}));
  assign upper = W'(-$signed({1'b0, diff_gain}));
  assign back_val = burg_pkg::sat32(SW'(r_b) - sh_w);

  // shared multiplier operands
  always_comb begin
    unique case (state)
      S_FG:    begin mul_a = $signed({2'b00, adv_gain}); mul_b = grid_rdata; end
      S_M2:    begin mul_a = 33'(lower);                 mul_b = up_prev;    end
      S_M3:    begin mul_a = 33'(lower);                 mul_b = rhs_prev;   end
      S_BM:    begin mul_a = 33'($signed(up_rdata));     mul_b = g_next;     end
      default: begin mul_a = $signed({2'b00, adv_gain}); mul_b = g;          end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = upper;
    div_req.den   = pivot;
    if (state == S_M4) begin
      div_req.start = 1'b1;
    end else if (state == S_DU && div_done) begin
      div_req.start = 1'b1;
      div_req.num   = num;
    end
  end

  // memory ports
  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = idx;
    grid_wdata = back_val;
    unique case (state)
      S_CLEAR: begin grid_we = 1'b1; grid_wdata = W'(ONE_Q); end
      S_B0:    begin grid_we = 1'b1; grid_waddr = LAST; grid_wdata = g; end
      S_BW:    grid_we = 1'b1;
      default: grid_we = 1'b0;
    endcase
    grid_raddr = (state == S_IDLE) ? rd_addr : idx;

    sw_we     = 1'b0;
    sw_addr   = idx;
    up_wdata  = up_cur;
    rhs_wdata = div_quot;
    if (state == S_IDLE && accept && !func) begin
      sw_we     = 1'b1;
      sw_addr   = '0;
      up_wdata  = '0;
      rhs_wdata = boundary_value;
    end else if (state == S_DR && div_done) begin
      sw_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (idx == LAST) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = func ? S_ROUT : S_FRD;
      S_FRD:   state_next = S_FG;
      S_FG:    state_next = S_M1;
      S_M1:    state_next = S_M2;
      S_M2:    state_next = S_M3;
      S_M3:    state_next = S_M4;
      S_M4:    state_next = S_DU;
      S_DU:    if (div_done) state_next = S_DR;
      S_DR:    if (div_done) state_next = (idx == LAST - 1'b1) ? S_B0 : S_FRD;
      S_B0:    state_next = S_BRD;
      S_BRD:   state_next = S_BM;
      S_BM:    state_next = S_BW;
      S_BW:    if (idx == '0) state_next = S_IDLE;
               else state_next = S_BRD;
      S_ROUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      adv_gain  <= 31'd2621440;
      diff_gain <= 31'd6553600;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ADV:  adv_gain  <= cfg_data;
          REG_DIFF: diff_gain <= cfg_data;
          default:  adv_gain  <= adv_gain;
        endcase
      end
      unique case (state)
        S_CLEAR: idx <= (idx == LAST) ? '0 : idx + 1'b1;
        S_IDLE:  if (accept) idx <= AW'(1);
        S_DR:    if (div_done && idx != LAST - 1'b1) idx <= idx + 1'b1;
        S_B0:    idx <= LAST - 1'b1;
        S_BW:    if (idx != '0) idx <= idx - 1'b1;
        default: idx <= idx;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        up_prev  <= '0;
        rhs_prev <= boundary_value;
      end
      S_FG: g <= grid_rdata;
      S_M1: begin
        lower <= burg_pkg::sat32(-au - beta);
        diag  <= burg_pkg::sat32(ONE_Q + au + (beta <<< 1));
      end
      S_M3: pivot <= burg_pkg::sat32(SW'(diag) - sh_w);
      S_M4: num   <= burg_pkg::sat32(SW'(g) - sh_w);
      S_DU: if (div_done) up_cur <= div_quot;
      S_DR: if (div_done) begin
        up_prev  <= up_cur;
        rhs_prev <= div_quot;
      end
      S_B0: g_next <= g;  // old u[N-1]
      S_BM: r_b    <= rhs_rdata;
      S_BW: g_next <= back_val;
      default: g_next <= g_next;
    endcase
  end

  burg_ram #(.WIDTH(W), .DEPTH(NPTS)) u_grid (
    .clk(clk), .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
    .raddr(grid_raddr), .rdata(grid_rdata)
  );

  burg_ram #(.WIDTH(W), .DEPTH(NPTS)) u_upper (
    .clk(clk), .we(sw_we), .waddr(sw_addr), .wdata(up_wdata),
    .raddr(idx), .rdata(up_rdata)
  );

  burg_ram #(.WIDTH(W), .DEPTH(NPTS)) u_rhs (
    .clk(clk), .we(sw_we), .waddr(sw_addr), .wdata(rhs_wdata),
    .raddr(idx), .rdata(rhs_rdata)
  );

  burg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .req(div_req),
    .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held more than one cycle");
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && func) |=> done)
    else $error("read item gave no result");
  a_no_grid_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !grid_we)
    else $error("grid written while idle");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

>>> sim/burg_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burg_tb_pkg: shared codes for the grid stepper testbench
// Item function codes and configuration register indexes.
// ----------------------------------------------------------------------------
package burg_tb_pkg;

  typedef enum logic {FN_STEP = 1'b0, FN_READ = 1'b1} grid_fn_e;
  typedef enum logic {REG_ADV_GAIN = 1'b0, REG_DIFF_GAIN = 1'b1} grid_reg_e;

  localparam int GRID_PTS  = 512;
  localparam int Q_FRAC    = 20;
  localparam int Q_ONE     = 1 << Q_FRAC;

endpackage

>>> sim/burg_grid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burg_grid_checker: predicts and checks grid point reads
// Mirrors the grid, solves each implicit step and compares every read result.
// ----------------------------------------------------------------------------
module burg_grid_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               func,
  input  logic signed [31:0] boundary_value,
  input  logic [9:0]         read_index,
  input  logic               done,
  input  logic signed [31:0] point_value,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [30:0]        cfg_data,
  output int                 fail_count,
  output int                 reads_pending
);

  int  grid_q [0:burg_tb_pkg::GRID_PTS];
  int  sw_up  [0:burg_tb_pkg::GRID_PTS];
  int  sw_rhs [0:burg_tb_pkg::GRID_PTS];
  longint adv_q;
  longint diff_q;
  int  point_due [$];

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // product shifted down, floor rounding
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> burg_tb_pkg::Q_FRAC;
  endfunction

  // truncating divide, zero divisor pins to the sign of the numerator (zero over zero gives zero)
  function automatic int fx_div(int num, int den);
    if (den == 0) begin
      if (num == 0) return 0;
      return (num > 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    end
    return clamp32((longint'(num) * burg_tb_pkg::Q_ONE) / longint'(den));
  endfunction

  task automatic advance_grid(int bnd);
    longint au;
    int     upper, lower, diag, pivot, num;
    upper = clamp32(-diff_q);
    sw_up[0]  = 0;
    sw_rhs[0] = bnd;
    for (int i = 1; i < burg_tb_pkg::GRID_PTS; i++) begin
      au     = fx_mul(adv_q, grid_q[i]);
      lower  = clamp32(-au - diff_q);
      diag   = clamp32(burg_tb_pkg::Q_ONE + au + 2 * diff_q);
      pivot  = clamp32(longint'(diag) - fx_mul(lower, sw_up[i-1]));
      num    = clamp32(longint'(grid_q[i]) - fx_mul(lower, sw_rhs[i-1]));
      sw_up[i]  = fx_div(upper, pivot);
      sw_rhs[i] = fx_div(num, pivot);
    end
    sw_up[burg_tb_pkg::GRID_PTS]  = 0;
    sw_rhs[burg_tb_pkg::GRID_PTS] = grid_q[burg_tb_pkg::GRID_PTS-1];
    grid_q[burg_tb_pkg::GRID_PTS] = sw_rhs[burg_tb_pkg::GRID_PTS];
    for (int i = burg_tb_pkg::GRID_PTS - 1; i >= 0; i--)
      grid_q[i] = clamp32(longint'(sw_rhs[i]) - fx_mul(sw_up[i], grid_q[i+1]));
  endtask

  assign reads_pending = point_due.size();

  always @(posedge clk) begin
    int idx;
    int want;
    if (rst) begin
      for (int i = 0; i <= burg_tb_pkg::GRID_PTS; i++) grid_q[i] = burg_tb_pkg::Q_ONE;
      adv_q  = 2621440;
      diff_q = 6553600;
      point_due.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (point_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected read result %h", $realtime, point_value);
        end else begin
          want = point_due.pop_front();
          if (point_value !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: point_value exp %h got %h", $realtime, want, point_value);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_addr == burg_tb_pkg::REG_ADV_GAIN) adv_q = longint'(cfg_data);
        else diff_q = longint'(cfg_data);
      end
      if (start && !busy) begin
        if (func == burg_tb_pkg::FN_STEP) advance_grid(boundary_value);
        else begin
          idx = (read_index > burg_tb_pkg::GRID_PTS) ? burg_tb_pkg::GRID_PTS : read_index;
          point_due.push_back(grid_q[idx]);
        end
      end
    end
  end

endmodule

>>> sim/tb_implicit_burgers_grid_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_implicit_burgers_grid_step: testbench for the implicit Burgers stepper
// Drives step, read and register traffic; the checker mirrors the grid and
// compares each read, this top only makes stimulus and reports.
// ----------------------------------------------------------------------------
module tb_implicit_burgers_grid_step;

  // the limit leaves room for every random item being a step, with margin
  localparam int CYCLE_LIMIT = 30_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               func = burg_tb_pkg::FN_READ;
  logic signed [31:0] boundary_value = '0;
  logic [9:0]         read_index = '0;
  logic               done;
  logic signed [31:0] point_value;
  logic               cfg_we = 1'b0;
  logic               cfg_addr = burg_tb_pkg::REG_ADV_GAIN;
  logic [30:0]        cfg_data = '0;

  int fail_count;
  int reads_pending;
  int cycles = 0;
  int n_step = 0, n_read = 0, n_cfg = 0;

  always #2 clk = ~clk;

  implicit_burgers_grid_step dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .boundary_value(boundary_value), .read_index(read_index), .done(done),
    .point_value(point_value), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  burg_grid_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .boundary_value(boundary_value), .read_index(read_index), .done(done),
    .point_value(point_value), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data), .fail_count(fail_count), .reads_pending(reads_pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one item. start is left high after the accept; the next call drops it
  // while busy is high, so even a zero gap leaves start low between items.
  task automatic send_item(burg_tb_pkg::grid_fn_e fn, logic signed [31:0] bnd,
                           logic [9:0] idx, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    // busy is low here and can only change at the coming edge: accepted there
    start          <= 1'b1;
    func           <= fn;
    boundary_value <= bnd;
    read_index     <= idx;
    if (fn == burg_tb_pkg::FN_STEP) n_step++;
    else n_read++;
  endtask

  // drain: start down, every read back, busy low, then a spare idle wait
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
    while (busy || reads_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(burg_tb_pkg::grid_reg_e r, logic [30:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= r;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    n_cfg++;
  endtask

  // mostly modest gains, sometimes the extremes
  function automatic logic [30:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(0, 4 << burg_tb_pkg::Q_FRAC));
      default: return 31'($urandom_range(0, 16 << burg_tb_pkg::Q_FRAC));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_boundary();
    case ($urandom_range(0, 4))
      0: return 32'($urandom);
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      default: return 32'($signed($urandom_range(0, 8 << burg_tb_pkg::Q_FRAC))
                          - (4 << burg_tb_pkg::Q_FRAC));
    endcase
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: reset grid, the read clamp, and the boundary extremes
    send_item(burg_tb_pkg::FN_READ, 0, 10'd0, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd512, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd513, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd1023, 1);
    send_item(burg_tb_pkg::FN_STEP, 32'sh7FFF_FFFF, 10'd0, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd0, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd1, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd511, 2);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd512, 0);
    send_item(burg_tb_pkg::FN_STEP, 32'sh8000_0000, 10'h3FF, 3);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd0, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd256, 0);
    settle();

    // no diffusion: upper is zero, so back substitution decouples; pivot is 1 + alpha*u
    write_reg(burg_tb_pkg::REG_ADV_GAIN, 31'(burg_tb_pkg::Q_ONE));
    write_reg(burg_tb_pkg::REG_DIFF_GAIN, 31'd0);
    send_item(burg_tb_pkg::FN_STEP, 32'sh0000_0000, 10'd0, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd1, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd512, 0);
    settle();

    // both gains at full scale: saturated coefficients
    write_reg(burg_tb_pkg::REG_ADV_GAIN, 31'h7FFF_FFFF);
    write_reg(burg_tb_pkg::REG_DIFF_GAIN, 31'h7FFF_FFFF);
    send_item(burg_tb_pkg::FN_STEP, -32'(burg_tb_pkg::Q_ONE), 10'd0, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd0, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd300, 0);
    send_item(burg_tb_pkg::FN_READ, 0, 10'd700, 0);
    settle();

    // random phases, new gains between them; steps kept rare since each is long
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(burg_tb_pkg::REG_ADV_GAIN, pick_gain());
      write_reg(burg_tb_pkg::REG_DIFF_GAIN, pick_gain());
      for (int k = 0; k < 25; k++) begin
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 11) == 0)
          send_item(burg_tb_pkg::FN_STEP, pick_boundary(), 10'($urandom), gap);
        else if ($urandom_range(0, 7) == 0)
          send_item(burg_tb_pkg::FN_READ, 32'($urandom), 10'($urandom_range(513, 1023)),
                    gap);
        else
          send_item(burg_tb_pkg::FN_READ, 32'($urandom), 10'($urandom_range(0, 512)), gap);
      end
      settle();
    end

    repeat (20) @(negedge clk);
    $display("ran %0d steps and %0d reads across %0d register writes", n_step, n_read,
             n_cfg);
    $display("gains went through zero, full scale and random values; %0d failures",
             fail_count);
    if (fail_count == 0 && reads_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/burg_pkg.sv
sv/burg_ram.sv
sv/burg_div.sv
sv/implicit_burgers_grid_step.sv
sim/burg_tb_pkg.sv
sim/burg_grid_checker.sv
sim/tb_implicit_burgers_grid_step.sv
